@@ rtl/mbp_pkg.sv @@
// ----------------------------------------------------------------------------
// mbp_pkg
// Shared constants and types for the mirror border padding block.
// ----------------------------------------------------------------------------
`default_nettype none

package mbp_pkg;

  // Frame store geometry
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int MAX_PAD    = 64;

  localparam int COL_BITS  = $clog2(MAX_WIDTH);
  localparam int ROW_BITS  = $clog2(MAX_HEIGHT);
  localparam int ADDR_BITS = COL_BITS + ROW_BITS;
  localparam int PIX_BITS  = 24;

  // Field and register widths
  localparam int COORD_W = 9;
  localparam int EXT_W   = COORD_W + 1;
  localparam int DIM_W   = 9;
  localparam int PAD_W   = 7;
  localparam int CFG_W   = 9;
  localparam int CFG_IDX_W = 2;

  // Request kinds
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_READ = 1'b1;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_PAD_WIDTH    = 2'd2;

  // Register reset values
  localparam logic [DIM_W-1:0] IMAGE_WIDTH_RESET  = 9'd256;
  localparam logic [DIM_W-1:0] IMAGE_HEIGHT_RESET = 9'd256;
  localparam logic [PAD_W-1:0] PAD_WIDTH_RESET    = 7'd0;

  // Result of mapping one padded axis index
  typedef struct packed {
    logic               pad_ok;  // inside the padded extent
    logic               src_ok;  // inside the source extent
    logic               hit;     // mirror lands on a source pixel
    logic [COORD_W-1:0] src;     // source index when hit
  } mbp_axis_t;

endpackage

`default_nettype wire

@@ rtl/mbp_axis_map.sv @@
// ----------------------------------------------------------------------------
// mbp_axis_map
// Maps one padded coordinate onto the source axis with edge-repeating mirror.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_axis_map (
  input  wire logic [mbp_pkg::COORD_W-1:0] p,
  input  wire logic [mbp_pkg::DIM_W-1:0]   n,
  input  wire logic [mbp_pkg::PAD_W-1:0]   pad,
  output mbp_pkg::mbp_axis_t               axis
);

  logic [mbp_pkg::EXT_W-1:0] pe;
  logic [mbp_pkg::EXT_W-1:0] ne;
  logic [mbp_pkg::EXT_W-1:0] de;
  logic [mbp_pkg::EXT_W-1:0] mid_end;
  logic [mbp_pkg::EXT_W-1:0] k_lo;
  logic [mbp_pkg::EXT_W-1:0] k_hi;
  logic [mbp_pkg::EXT_W-1:0] src_ext;
  logic                      in_lo;
  logic                      in_mid;
  logic                      hit;

  assign pe      = {1'b0, p};
  assign ne      = {{(mbp_pkg::EXT_W-mbp_pkg::DIM_W){1'b0}}, n};
  assign de      = {{(mbp_pkg::EXT_W-mbp_pkg::PAD_W){1'b0}}, pad};
  assign mid_end = de + ne;
  assign in_lo   = pe < de;
  assign in_mid  = !in_lo && (pe < mid_end);
  assign k_lo    = de - pe - 10'd1;
  assign k_hi    = pe - mid_end;

  always_comb begin
    if (in_lo) begin
      hit     = k_lo < ne;
      src_ext = k_lo;
    end else if (in_mid) begin
      hit     = 1'b1;
      src_ext = pe - de;
    end else begin
      // far border: mirror back from the last source pixel
      hit     = k_hi < ne;
      src_ext = ne - k_hi - 10'd1;
    end
  end

  assign axis.pad_ok = pe < (mid_end + de);
  assign axis.src_ok = pe < ne;
  assign axis.hit    = hit;
  assign axis.src    = src_ext[mbp_pkg::COORD_W-1:0];

endmodule

`default_nettype wire

@@ rtl/mbp_store.sv @@
// ----------------------------------------------------------------------------
// mbp_store
// Single-port frame store, one access per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module mbp_store (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic                          re,
  input  wire logic [mbp_pkg::ADDR_BITS-1:0] addr,
  input  wire logic [mbp_pkg::PIX_BITS-1:0]  wdata,
  output logic      [mbp_pkg::PIX_BITS-1:0]  rdata
);

  logic [mbp_pkg::PIX_BITS-1:0] mem [mbp_pkg::MAX_WIDTH*mbp_pkg::MAX_HEIGHT];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/mirror_border_padding.sv @@
// ----------------------------------------------------------------------------
// mirror_border_padding
// RGB888 frame store that answers reads of a mirror-padded image.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on start while busy is low. A load (req_type 0) writes
//   red_in/green_in/blue_in at source (col,row); a read (req_type 1) takes a
//   padded (col,row) and returns the mirrored source pixel, black with
//   black_fill where the mirror misses the image, and out_of_range where the
//   coordinate lies outside the source (load) or padded (read) image.
//   Each request yields one result: done is high for one cycle with the
//   colour and flag ports valid. A request is registered in the request
//   stage; its flags and store read data are then registered in the result
//   stage, together with done. Throughput is one request per cycle while
//   busy is low: the store has one port and each request makes at most one
//   access to it, in the middle stage. Registers image_width, image_height
//   and pad_width are written through wr_en/wr_index/wr_data; the user
//   must write them only while no request is in flight, which the block
//   does not enforce. Reset clears the pipeline and restores the register
//   defaults; busy is high during reset. The frame store is not cleared.
//   The receiver cannot stall: done is a one-cycle strobe.
// ----------------------------------------------------------------------------
`default_nettype none

module mirror_border_padding (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  output logic                               busy,
  input  wire logic                          wr_en,
  input  wire logic [mbp_pkg::CFG_IDX_W-1:0] wr_index,
  input  wire logic [mbp_pkg::CFG_W-1:0]     wr_data,
  input  wire logic                          req_type,
  input  wire logic [mbp_pkg::COORD_W-1:0]   col,
  input  wire logic [mbp_pkg::COORD_W-1:0]   row,
  input  wire logic [7:0]                    red_in,
  input  wire logic [7:0]                    green_in,
  input  wire logic [7:0]                    blue_in,
  output logic                               done,
  output logic      [7:0]                    red_out,
  output logic      [7:0]                    green_out,
  output logic      [7:0]                    blue_out,
  output logic                               black_fill,
  output logic                               out_of_range
);

  // Configuration registers
  logic [mbp_pkg::DIM_W-1:0] image_width;
  logic [mbp_pkg::DIM_W-1:0] image_height;
  logic [mbp_pkg::PAD_W-1:0] pad_width;

  // Effective geometry
  logic [mbp_pkg::DIM_W-1:0] w_eff;
  logic [mbp_pkg::DIM_W-1:0] h_eff;
  logic [mbp_pkg::PAD_W-1:0] pad_eff;

  // Request stage
  logic                        s1_valid;
  logic                        s1_type;
  logic [mbp_pkg::COORD_W-1:0] s1_col;
  logic [mbp_pkg::COORD_W-1:0] s1_row;
  logic [mbp_pkg::PIX_BITS-1:0] s1_pix;

  // Access stage
  mbp_pkg::mbp_axis_t          col_map;
  mbp_pkg::mbp_axis_t          row_map;
  logic                        s1_oor;
  logic                        s1_black;
  logic                        mem_we;
  logic                        mem_re;
  logic [mbp_pkg::ADDR_BITS-1:0] mem_addr;
  logic [mbp_pkg::COORD_W-1:0] addr_col;
  logic [mbp_pkg::COORD_W-1:0] addr_row;
  logic [mbp_pkg::PIX_BITS-1:0] mem_rdata;

  // Result stage
  logic s2_hit;
  logic s2_black;
  logic s2_oor;

  assign busy = rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= mbp_pkg::IMAGE_WIDTH_RESET;
      image_height <= mbp_pkg::IMAGE_HEIGHT_RESET;
      pad_width    <= mbp_pkg::PAD_WIDTH_RESET;
    end else if (wr_en) begin
      unique case (wr_index)
        mbp_pkg::REG_IMAGE_WIDTH:  image_width  <= wr_data;
        mbp_pkg::REG_IMAGE_HEIGHT: image_height <= wr_data;
        mbp_pkg::REG_PAD_WIDTH:    pad_width    <= wr_data[mbp_pkg::PAD_W-1:0];
        default: ;
      endcase
    end
  end

  // Zero size acts as one; oversize saturates to the store bounds, pad width to MAX_PAD
  always_comb begin
    if (image_width == '0) begin
      w_eff = 9'd1;
    end else if (image_width > 9'(mbp_pkg::MAX_WIDTH)) begin
      w_eff = 9'(mbp_pkg::MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    if (image_height == '0) begin
      h_eff = 9'd1;
    end else if (image_height > 9'(mbp_pkg::MAX_HEIGHT)) begin
      h_eff = 9'(mbp_pkg::MAX_HEIGHT);
    end else begin
      h_eff = image_height;
    end
    pad_eff = (pad_width > 7'(mbp_pkg::MAX_PAD)) ? 7'(mbp_pkg::MAX_PAD) : pad_width;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else begin
      s1_valid <= start && !busy;
    end
  end

  always_ff @(posedge clk) begin
    if (start && !busy) begin
      s1_type <= req_type;
      s1_col  <= col;
      s1_row  <= row;
      s1_pix  <= {red_in, green_in, blue_in};
    end
  end

  mbp_axis_map u_col_map (
    .p    (s1_col),
    .n    (w_eff),
    .pad  (pad_eff),
    .axis (col_map)
  );

  mbp_axis_map u_row_map (
    .p    (s1_row),
    .n    (h_eff),
    .pad  (pad_eff),
    .axis (row_map)
  );

  always_comb begin
    if (s1_type == mbp_pkg::REQ_LOAD) begin
      s1_oor   = !(col_map.src_ok && row_map.src_ok);
      s1_black = 1'b0;
      addr_col = s1_col;
      addr_row = s1_row;
    end else begin
      s1_oor   = !(col_map.pad_ok && row_map.pad_ok);
      s1_black = !s1_oor && !(col_map.hit && row_map.hit);
      addr_col = col_map.src;
      addr_row = row_map.src;
    end
  end

  assign mem_addr = {addr_row[mbp_pkg::ROW_BITS-1:0], addr_col[mbp_pkg::COL_BITS-1:0]};
  assign mem_we   = s1_valid && (s1_type == mbp_pkg::REQ_LOAD) && !s1_oor;
  assign mem_re   = s1_valid && (s1_type == mbp_pkg::REQ_READ) && !s1_oor && !s1_black;

  mbp_store u_store (
    .clk   (clk),
    .we    (mem_we),
    .re    (mem_re),
    .addr  (mem_addr),
    .wdata (s1_pix),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      done <= 1'b0;
    end else begin
      done <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    s2_hit   <= mem_re;
    s2_black <= s1_black;
    s2_oor   <= s1_oor;
  end

  // Drop the colour unless the store was read for this request
  assign red_out      = s2_hit ? mem_rdata[23:16] : 8'd0;
  assign green_out    = s2_hit ? mem_rdata[15:8]  : 8'd0;
  assign blue_out     = s2_hit ? mem_rdata[7:0]   : 8'd0;
  assign black_fill   = s2_black;
  assign out_of_range = s2_oor;

  // Every accepted request produces its result on done, after the request and result stages
  assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> ##1 done)
    else $error("accepted request produced no result");

  // The single store port is never asked for a write and a read together
  assert property (@(posedge clk) disable iff (rst)
    !(mem_we && mem_re))
    else $error("store write and read in the same cycle");

  // A black or out-of-range result never carries store data
  assert property (@(posedge clk) disable iff (rst)
    (done && (black_fill || out_of_range)) |-> !s2_hit)
    else $error("flagged result carries store data");

  // A store access only happens for a request in flight
  assert property (@(posedge clk) disable iff (rst)
    (mem_we || mem_re) |-> $past(start && !busy))
    else $error("store access without a request");

endmodule

`default_nettype wire
